// File: design/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg: shared types for the positional array list
// Entry layout, action and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package pal_pkg;

  typedef struct packed {
    logic [63:0]        word;
    logic signed [15:0] price;
  } entry_t;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_hit;
  } cell_ctl_t;

endpackage

// File: design/pal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell: one slot of the list
// Holds one entry and one stage of the read chain toward slot zero.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  input  entry_t    read_in,
  output entry_t    entry_out,
  output entry_t    read_out
);

  entry_t entry;
  entry_t rd;

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_HOLD:       entry <= entry;
      OP_LOAD:       entry <= new_entry;
      OP_SHIFT_UP:   entry <= left_entry;
      OP_SHIFT_DOWN: entry <= right_entry;
      OP_CLEAR:      entry <= '0;
      default:       entry <= entry;
    endcase
    // The hit slot injects its entry; every other slot passes its right
    // neighbor's value one step down.
    rd <= ctl.rd_hit ? entry : read_in;
  end

  assign entry_out = entry;
  assign read_out  = rd;

endmodule

// File: design/positional_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list: ordered list with append, insert, delete and read
// A row of CAPACITY cells shifts all entries together; reads drain through
// a registered chain of the same cells.
// ----------------------------------------------------------------------------
// Results: append, insert, delete and any rejected action load their result
//   word into the output register as they are accepted. A valid read loads
//   its word once the READ state has let the hit entry drain through the
//   read chain, which moves one cell per cycle toward cell zero.
// Throughput: one word per cycle for non-read actions while no pending result
//   is stalled; a valid read holds off the input until its word is loaded.
// Reset: clears the entry count and the control state; cell contents are
//   left as they are and are never read before they are written.
module positional_array_list import pal_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [6:0]         position,
  input  logic [63:0]        entry_word,
  input  logic signed [15:0] entry_price,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [6:0]         entry_count,
  output logic [63:0]        read_word,
  output logic signed [15:0] read_price
);

  // Count width holds CAPACITY itself; index width addresses the cells.
  // Comparisons run at PW bits so that the 7-bit position and the count line up.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 7) ? CW : 7;

  typedef enum logic {
    IDLE,
    READ
  } state_t;

  state_t          state;
  logic [CW-1:0]   held_count;
  logic [IW-1:0]   rd_idx;
  logic [CW-1:0]   rd_cnt;

  entry_t          new_entry;
  entry_t          cell_entry [CAPACITY];
  entry_t          cell_read  [CAPACITY];
  cell_ctl_t       cell_ctl   [CAPACITY];

  logic            accept;
  logic            full;
  logic [PW-1:0]   pos_w;
  logic [PW-1:0]   cnt_w;
  logic [PW-1:0]   cnt_next_w;
  logic            ins_ok;
  logic            pos_ok;
  logic            change;
  logic [CW-1:0]   held_count_next;
  status_t         status_next;
  action_t         act;

  assign act       = action_t'(action);
  assign in_stall  = (state == READ) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign new_entry = '{word: entry_word, price: entry_price};

  assign full   = (held_count == CW'(CAPACITY));
  assign pos_w  = PW'(position);
  assign cnt_w  = PW'(held_count);
  assign ins_ok = !full && (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign pos_ok = (pos_w != '0) && (pos_w <= cnt_w);

  // Decode the action into a status and the next count.
  always_comb begin
    status_next     = ST_OK;
    held_count_next = held_count;
    change          = 1'b0;
    case (act)
      ACT_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          held_count_next = held_count + CW'(1);
          change          = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (!ins_ok) begin
          status_next = ST_BAD;
        end else begin
          held_count_next = held_count + CW'(1);
          change          = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (!pos_ok) begin
          status_next = ST_BAD;
        end else begin
          held_count_next = held_count - CW'(1);
          change          = 1'b1;
        end
      end
      ACT_READ: begin
        if (!pos_ok) begin
          status_next = ST_BAD;
        end
      end
      default: status_next = ST_BAD;
    endcase
  end

  assign cnt_next_w = PW'(held_count_next);

  // Each cell compares its own index against the position and the count.
  // An insert opens a gap at the position by moving later cells up; a
  // delete closes it by moving them down and zeroes the freed tail slot.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].rd_hit = (rd_idx == IW'(i));
      cell_ctl[i].op     = OP_HOLD;
      if (accept && change) begin
        case (act)
          ACT_APPEND: begin
            if (PW'(i) == cnt_w) begin
              cell_ctl[i].op = OP_LOAD;
            end
          end
          ACT_INSERT: begin
            if (PW'(i) == pos_w - PW'(1)) begin
              cell_ctl[i].op = OP_LOAD;
            end else if (PW'(i) > pos_w - PW'(1)) begin
              cell_ctl[i].op = OP_SHIFT_UP;
            end
          end
          ACT_DELETE: begin
            if (PW'(i) == cnt_w - PW'(1)) begin
              cell_ctl[i].op = OP_CLEAR;
            end else if (PW'(i) >= pos_w - PW'(1)) begin
              cell_ctl[i].op = OP_SHIFT_DOWN;
            end
          end
          default: cell_ctl[i].op = OP_HOLD;
        endcase
      end
    end
  end

  // The row of cells. Cell zero has no left neighbor and the last cell has
  // no right neighbor; both see zero there, which also ends the read chain.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    entry_t chain_in;

    if (g == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = cell_entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_e  = '0;
      assign chain_in = '0;
    end else begin : g_inner
      assign right_e  = cell_entry[g+1];
      assign chain_in = cell_read[g+1];
    end

    pal_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[g]),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .read_in     (chain_in),
      .entry_out   (cell_entry[g]),
      .read_out    (cell_read[g])
    );
  end

  // Control and the output register. A valid read stays in READ until rd_cnt
  // reaches CAPACITY, with the hit entry at cell zero, then loads the result.
  // In IDLE a pending result word is either replaced by the next one or
  // dropped once it is taken; during a read drain no word is pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      held_count <= '0;
      out_valid  <= 1'b0;
      rd_idx     <= '0;
      rd_cnt     <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            held_count <= held_count_next;
            if (act == ACT_READ && status_next == ST_OK) begin
              state     <= READ;
              out_valid <= 1'b0;
              rd_idx    <= IW'(pos_w - PW'(1));
              rd_cnt    <= '0;
            end else begin
              out_valid   <= 1'b1;
              status      <= status_next;
              entry_count <= cnt_next_w[6:0];
              read_word   <= '0;
              read_price  <= '0;
            end
          end else if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        READ: begin
          if (rd_cnt == CW'(CAPACITY)) begin
            state       <= IDLE;
            out_valid   <= 1'b1;
            status      <= ST_OK;
            entry_count <= cnt_w[6:0];
            read_word   <= cell_read[0].word;
            read_price  <= cell_read[0].price;
          end else begin
            rd_cnt <= rd_cnt + CW'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // The count never runs past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // While a read drains, no result is pending and the input is held off.
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    state == READ |-> !out_valid && in_stall)
    else $error("result pending during read drain");

  // A successful append grows the count by exactly one.
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    accept && act == ACT_APPEND && !full |=> held_count == $past(held_count) + CW'(1))
    else $error("append did not grow the count");

  // A rejected action returns zero read fields.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> read_word == '0 && read_price == '0)
    else $error("rejected action returned read data");

endmodule
